// ===== hdl/consensus_follower_rpc_handler_macros.svh =====
// ---------------------------------------------------------------------------
// consensus_follower_rpc_handler_macros.svh
// Assertion macros for the follower request handler; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef CONSENSUS_FOLLOWER_RPC_HANDLER_MACROS_SVH
`define CONSENSUS_FOLLOWER_RPC_HANDLER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CFRH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfrh assertion failed");
// next-cycle implication
`define CFRH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfrh assertion failed");
`else
`define CFRH_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CFRH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/cfrh_pkg.sv =====
// ---------------------------------------------------------------------------
// cfrh_pkg
// Shared constants and types of the follower request handler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfrh_pkg;

    localparam int LOG_DEPTH = 1024;
    localparam int ADDR_W    = $clog2(LOG_DEPTH);
    localparam int IDX_W     = $clog2(LOG_DEPTH + 1);
    localparam int TERM_W    = 32;
    localparam int ID_W      = 4;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_VOTE   = 1'b1;
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_VOTE   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [TERM_W-1:0] request_term;
        logic [IDX_W-1:0]  prev_index;
        logic [TERM_W-1:0] prev_term;
        logic              has_entry;
        logic [IDX_W-1:0]  leader_commit;
        logic [ID_W-1:0]   candidate_id;
        logic [IDX_W-1:0]  cand_last_index;
        logic              node_is_candidate;
        logic              node_is_leader;
    } t_req;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch request, read entry term at prev_index
        logic commit;  // update state, load reply register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic reply;   // latched request produces a reply
    } t_sts;

endpackage

// ===== hdl/consensus_follower_rpc_handler.sv =====
// ---------------------------------------------------------------------------
// consensus_follower_rpc_handler
// Follower-side append and vote request handler of a consensus node.
// ---------------------------------------------------------------------------
// On accept, the handler latches the request and reads the stored entry
// term at prev_index from the single-port term memory. It then waits until
// no earlier reply is stalled at the output, and checks the request, writes
// back any appended term, updates term, vote and commit state and loads the
// reply register; no new item is taken before that. Entry 0 of the term
// store reads as zero from reset; no clearing pass is needed, so the block
// accepts items as soon as reset is released. Vote requests while leading
// give no reply item.
`timescale 1ns / 1ps
`include "consensus_follower_rpc_handler_macros.svh"

module consensus_follower_rpc_handler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [cfrh_pkg::TERM_W-1:0]   i_request_term,
    input  logic [cfrh_pkg::IDX_W-1:0]    i_prev_index,
    input  logic [cfrh_pkg::TERM_W-1:0]   i_prev_term,
    input  logic                          i_has_entry,
    input  logic [cfrh_pkg::IDX_W-1:0]    i_leader_commit,
    input  logic [cfrh_pkg::ID_W-1:0]     i_candidate_id,
    input  logic [cfrh_pkg::IDX_W-1:0]    i_cand_last_index,
    input  logic                          i_node_is_candidate,
    input  logic                          i_node_is_leader,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_reply_kind,
    output logic [cfrh_pkg::TERM_W-1:0]   o_reply_term,
    output logic                          o_granted,
    output logic                          o_log_full
);

    cfrh_pkg::t_cmd cmd;
    cfrh_pkg::t_sts sts;
    cfrh_pkg::t_req req;

    assign req.mode              = i_mode;
    assign req.request_term      = i_request_term;
    assign req.prev_index        = i_prev_index;
    assign req.prev_term         = i_prev_term;
    assign req.has_entry         = i_has_entry;
    assign req.leader_commit     = i_leader_commit;
    assign req.candidate_id      = i_candidate_id;
    assign req.cand_last_index   = i_cand_last_index;
    assign req.node_is_candidate = i_node_is_candidate;
    assign req.node_is_leader    = i_node_is_leader;

    cfrh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cfrh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req        (req),
        .o_sts        (sts),
        .o_reply_kind (o_reply_kind),
        .o_reply_term (o_reply_term),
        .o_granted    (o_granted),
        .o_log_full   (o_log_full)
    );

    // an accepted item is in work on the next cycle
    `CFRH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a committed item frees the input side
    `CFRH_ASSERT_NEXT(a_commit_idle, i_clk, i_rst_n, cmd.commit, !o_in_stall)
    // loading and committing never overlap
    `CFRH_ASSERT_NOW(a_load_xor_commit, i_clk, i_rst_n, cmd.load, !cmd.commit)
    // a commit never overwrites a reply that is still stalled
    `CFRH_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.commit && o_out_valid, !i_out_stall)

endmodule

// ===== hdl/cfrh_ctrl.sv =====
// ---------------------------------------------------------------------------
// cfrh_ctrl
// Sequencer: accepts one item, then commits it once the reply slot is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfrh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  cfrh_pkg::t_sts  i_sts,
    output cfrh_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the reply register can take the result
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = i_sts.reply;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hdl/cfrh_dp.sv =====
// ---------------------------------------------------------------------------
// cfrh_dp
// Term, vote and commit state, entry term memory and reply register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfrh_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfrh_pkg::t_cmd                i_cmd,
    input  cfrh_pkg::t_req                i_req,
    output cfrh_pkg::t_sts                o_sts,
    output logic                          o_reply_kind,
    output logic [cfrh_pkg::TERM_W-1:0]   o_reply_term,
    output logic                          o_granted,
    output logic                          o_log_full
);

    logic [cfrh_pkg::TERM_W-1:0] r_mem [cfrh_pkg::LOG_DEPTH];
    logic [cfrh_pkg::TERM_W-1:0] r_rd_data;
    cfrh_pkg::t_req              r_req;

    logic [cfrh_pkg::TERM_W-1:0] r_cur_term,   n_cur_term;
    logic                        r_voted_valid, n_voted_valid;
    logic [cfrh_pkg::ID_W-1:0]   r_voted_id,   n_voted_id;
    logic                        r_has_voted,  n_has_voted;
    logic [cfrh_pkg::IDX_W-1:0]  r_commit,     n_commit;
    logic [cfrh_pkg::IDX_W-1:0]  r_log_count,  n_log_count;

    logic                        r_reply_kind;
    logic [cfrh_pkg::TERM_W-1:0] r_reply_term;
    logic                        r_granted;
    logic                        r_log_full;

    logic [cfrh_pkg::TERM_W-1:0] stored_term;
    logic                        wr_en;
    logic                        reply;
    logic                        n_granted;
    logic                        n_log_full;
    logic                        append_try;
    logic                        record_ok;

    // entry 0 is never written and reads as zero
    assign stored_term = (r_req.prev_index == '0) ? '0 : r_rd_data;

    always_comb begin
        n_cur_term    = r_cur_term;
        n_voted_valid = r_voted_valid;
        n_voted_id    = r_voted_id;
        n_has_voted   = r_has_voted;
        n_commit      = r_commit;
        n_log_count   = r_log_count;
        wr_en         = 1'b0;
        reply         = 1'b1;
        n_granted     = 1'b0;
        n_log_full    = 1'b0;
        append_try    = 1'b0;
        record_ok     = 1'b0;
        if (r_req.mode == cfrh_pkg::MODE_APPEND) begin
            priority if (r_req.request_term < r_cur_term) begin
                n_granted = 1'b0;
            end else if ((r_req.prev_index < r_log_count)
                         && (stored_term != r_req.prev_term)) begin
                n_granted = 1'b0;
            end else begin
                append_try = r_req.has_entry && (r_log_count <= r_req.prev_index);
                if (append_try) begin
                    if (r_log_count == cfrh_pkg::IDX_W'(cfrh_pkg::LOG_DEPTH)) begin
                        n_log_full = 1'b1;
                    end else begin
                        wr_en       = 1'b1;
                        n_log_count = r_log_count + 1'b1;
                    end
                end
                if (r_req.leader_commit > r_commit) begin
                    n_commit = (r_req.leader_commit < n_log_count)
                             ? r_req.leader_commit : n_log_count;
                end
                n_granted = !n_log_full;
            end
        end else if (r_req.node_is_leader) begin
            // vote while leading: drop silently
            reply = 1'b0;
        end else begin
            if (r_cur_term < r_req.request_term) begin
                n_cur_term    = r_req.request_term;
                n_has_voted   = 1'b0;
                n_voted_valid = 1'b0;
            end
            record_ok = !n_voted_valid || (r_voted_id == r_req.candidate_id);
            n_granted = !(r_req.request_term < n_cur_term)
                      && (record_ok || (r_req.cand_last_index >= r_commit))
                      && !n_has_voted && !r_req.node_is_candidate;
            if (n_granted) begin
                n_voted_id    = r_req.candidate_id;
                n_voted_valid = 1'b1;
                n_has_voted   = 1'b1;
            end
        end
    end

    assign o_sts.reply = reply;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            r_mem[r_log_count[cfrh_pkg::ADDR_W-1:0]] <= r_req.request_term;
        end
        if (i_cmd.load) begin
            r_rd_data <= r_mem[i_req.prev_index[cfrh_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.commit && reply) begin
            r_reply_kind <= r_req.mode ? cfrh_pkg::KIND_VOTE : cfrh_pkg::KIND_APPEND;
            r_reply_term <= n_cur_term;
            r_granted    <= n_granted;
            r_log_full   <= n_log_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_term    <= '0;
            r_voted_valid <= 1'b0;
            r_voted_id    <= '0;
            r_has_voted   <= 1'b0;
            r_commit      <= '0;
            r_log_count   <= cfrh_pkg::IDX_W'(1);
        end else if (i_cmd.commit) begin
            r_cur_term    <= n_cur_term;
            r_voted_valid <= n_voted_valid;
            r_voted_id    <= n_voted_id;
            r_has_voted   <= n_has_voted;
            r_commit      <= n_commit;
            r_log_count   <= n_log_count;
        end
    end

    assign o_reply_kind = r_reply_kind;
    assign o_reply_term = r_reply_term;
    assign o_granted    = r_granted;
    assign o_log_full   = r_log_full;

endmodule
